### hdl/stick_zone_quantizer_top_assert.svh
// Assertion macros shared by the stick zone quantizer RTL.
`ifndef STICK_ZONE_QUANTIZER_TOP_ASSERT_SVH
`define STICK_ZONE_QUANTIZER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clock and disabled in reset.
`define SZQ_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled in reset.
`define SZQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/szq_pkg.sv
// Types and constants of the stick zone quantizer.
`timescale 1ns / 1ps
`default_nettype none

package szq_pkg;

   // Width of the per-stick hold counters.
   localparam int HOLD_COUNT_BITS = 8;
   localparam int STABLE_FRAMES_W = 8;
   localparam int HOLD_CMP_W =
      (HOLD_COUNT_BITS > STABLE_FRAMES_W) ? HOLD_COUNT_BITS : STABLE_FRAMES_W;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Zone geometry in Q15.
   localparam int BOUND_HALF  = 16384;
   localparam int HALF_WIDTH  = 8192;
   localparam int CENTRE_ZONE0 = -24576;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      REG_DEADZONE      = 2'd0,
      REG_HYSTERESIS    = 2'd1,
      REG_STABLE_FRAMES = 2'd2
   } reg_index_type;

   typedef logic signed [15:0] axis_type;
   typedef logic [1:0]         zone_type;
   typedef logic [13:0]        conf_type;

   // One input beat: four raw Q15 axes.
   typedef struct packed {
      axis_type left_x;
      axis_type left_y;
      axis_type right_x;
      axis_type right_y;
   } req_type;

   // One result beat.
   typedef struct packed {
      zone_type left_zone_x;
      zone_type left_zone_y;
      zone_type right_zone_x;
      zone_type right_zone_y;
      conf_type left_confidence;
      conf_type right_confidence;
      logic     left_stable;
      logic     right_stable;
   } rsp_type;

endpackage

`default_nettype wire

### hdl/stick_zone_quantizer_top.sv
// Stick zone quantizer: deadzone, four-zone hysteresis quantizer, confidence and stability.
// Path: an accepted beat is registered in s1_data_ff, its result in rsp_data_ff.
// Throughput: one beat per cycle without rsp_stall; prior axes and zones update per beat.
// The only loop is the previous-sample state.
// Reset (synchronous): config to defaults; valids, previous axes, zones, counters to zero.
// Nothing needs a clearing pass; the block accepts beats right after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "stick_zone_quantizer_top_assert.svh"

module stick_zone_quantizer_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  szq_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output szq_pkg::rsp_type                 rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [szq_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [szq_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [szq_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import szq_pkg::*;

   localparam logic signed [17:0] BoundS = 18'(BOUND_HALF);
   localparam logic signed [17:0] HalfS  = 18'(HALF_WIDTH);
   localparam logic [HOLD_COUNT_BITS-1:0] HoldMax = '1;

   // Configuration registers.
   logic [14:0]                deadzone_ff;
   logic [14:0]                hysteresis_ff;
   logic [STABLE_FRAMES_W-1:0] stable_frames_ff;

   // Pipeline registers.
   logic    s1_valid_ff;
   req_type s1_data_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // State carried from beat to beat.
   axis_type                   prev_raw_ff  [4];
   zone_type                   zone_hist_ff [4];
   logic [HOLD_COUNT_BITS-1:0] hold_cnt_ff  [2];
   logic [HOLD_COUNT_BITS-1:0] hold_cnt_in  [2];

   // Handshake.
   logic    s1_load;
   logic    s2_load;
   logic    s1_valid_in;
   logic    rsp_valid_in;
   logic    cfg_write;
   rsp_type rsp_data_in;

   // Per-axis datapath.
   axis_type          raw        [4];
   logic signed [17:0] raw_ext   [4];
   logic signed [17:0] dzd       [4];
   logic signed [17:0] dist_min  [4];
   zone_type          zone_dz    [4];
   zone_type          zone_prev  [4];
   zone_type          zone_new   [4];
   conf_type          conf_axis  [4];
   logic              stable_new [2];
   conf_type          conf_stick [2];

   function automatic zone_type zone_of(input logic signed [17:0] a);
      zone_type z;
      if (a < -BoundS) begin
         z = 2'd0;
      end else if (a < 18'sd0) begin
         z = 2'd1;
      end else if (a < BoundS) begin
         z = 2'd2;
      end else begin
         z = 2'd3;
      end
      return z;
   endfunction

   function automatic logic signed [17:0] abs18(input logic signed [17:0] v);
      return (v < 18'sd0) ? -v : v;
   endfunction

   function automatic logic signed [17:0] centre_of(input zone_type z);
      return 18'(CENTRE_ZONE0) + $signed({2'b00, z, 14'd0});
   endfunction

   // Handshake: the input register drains into the result register.
   assign s2_load      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = s1_valid_ff && !s2_load;
   assign s1_load      = req_valid && !req_stall;
   assign s1_valid_in  = s1_load || (s1_valid_ff && !s2_load);
   assign rsp_valid_in = s2_load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   // Configuration port: a write lands in the access phase.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      case (reg_index_type'(paddr[3:2]))
         REG_DEADZONE:      prdata = CSR_DATA_W'(deadzone_ff);
         REG_HYSTERESIS:    prdata = CSR_DATA_W'(hysteresis_ff);
         REG_STABLE_FRAMES: prdata = CSR_DATA_W'(stable_frames_ff);
         default:           prdata = '0;
      endcase
   end

   // Unpack the registered beat.
   assign raw[0] = s1_data_ff.left_x;
   assign raw[1] = s1_data_ff.left_y;
   assign raw[2] = s1_data_ff.right_x;
   assign raw[3] = s1_data_ff.right_y;

   // Deadzone, zoning, hysteresis and per-axis confidence.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         raw_ext[i] = 18'(raw[i]);
         if ((raw_ext[i] > -$signed({3'b000, deadzone_ff}))
             && (raw_ext[i] < $signed({3'b000, deadzone_ff}))) begin
            dzd[i] = 18'sd0;
         end else begin
            dzd[i] = raw_ext[i];
         end
         zone_dz[i]   = zone_of(dzd[i]);
         zone_prev[i] = zone_of(18'(prev_raw_ff[i]));

         // Distance to the nearest inner boundary.
         dist_min[i] = abs18(dzd[i] + BoundS);
         if (abs18(dzd[i]) < dist_min[i]) begin
            dist_min[i] = abs18(dzd[i]);
         end
         if (abs18(dzd[i] - BoundS) < dist_min[i]) begin
            dist_min[i] = abs18(dzd[i] - BoundS);
         end

         if ((prev_raw_ff[i] != '0) && (zone_prev[i] != zone_dz[i])
             && (dist_min[i] < $signed({3'b000, hysteresis_ff}))) begin
            zone_new[i] = zone_prev[i];
         end else begin
            zone_new[i] = zone_dz[i];
         end

         // Closeness of the raw axis to its zone centre.
         if (abs18(raw_ext[i] - centre_of(zone_new[i])) >= HalfS) begin
            conf_axis[i] = '0;
         end else begin
            conf_axis[i] = 14'(HalfS - abs18(raw_ext[i] - centre_of(zone_new[i])));
         end
      end
   end

   // Per-stick confidence, hold counter and stable flag.
   always_comb begin
      for (int s = 0; s < 2; s++) begin
         conf_stick[s] = 14'(({1'b0, conf_axis[2*s]} + {1'b0, conf_axis[2*s+1]}) >> 1);
         if ((zone_new[2*s] == zone_hist_ff[2*s])
             && (zone_new[2*s+1] == zone_hist_ff[2*s+1])) begin
            hold_cnt_in[s] = (hold_cnt_ff[s] == HoldMax) ? hold_cnt_ff[s]
                                                         : hold_cnt_ff[s] + 1'b1;
         end else begin
            hold_cnt_in[s] = '0;
         end
         stable_new[s] = HOLD_CMP_W'(hold_cnt_in[s]) >= HOLD_CMP_W'(stable_frames_ff);
      end
   end

   // Assemble the result beat.
   always_comb begin
      rsp_data_in.left_zone_x      = zone_new[0];
      rsp_data_in.left_zone_y      = zone_new[1];
      rsp_data_in.right_zone_x     = zone_new[2];
      rsp_data_in.right_zone_y     = zone_new[3];
      rsp_data_in.left_confidence  = conf_stick[0];
      rsp_data_in.right_confidence = conf_stick[1];
      rsp_data_in.left_stable      = stable_new[0];
      rsp_data_in.right_stable     = stable_new[1];
   end

   // Control, configuration and carried state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         deadzone_ff      <= 15'd3277;
         hysteresis_ff    <= 15'd1638;
         stable_frames_ff <= 8'd3;
         for (int i = 0; i < 4; i++) begin
            prev_raw_ff[i]  <= '0;
            zone_hist_ff[i] <= '0;
         end
         hold_cnt_ff[0] <= '0;
         hold_cnt_ff[1] <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_write) begin
            case (reg_index_type'(paddr[3:2]))
               REG_DEADZONE:      deadzone_ff      <= pwdata[14:0];
               REG_HYSTERESIS:    hysteresis_ff    <= pwdata[14:0];
               REG_STABLE_FRAMES: stable_frames_ff <= pwdata[STABLE_FRAMES_W-1:0];
               default:           ;
            endcase
         end
         if (s2_load) begin
            for (int i = 0; i < 4; i++) begin
               prev_raw_ff[i]  <= raw[i];
               zone_hist_ff[i] <= zone_new[i];
            end
            hold_cnt_ff[0] <= hold_cnt_in[0];
            hold_cnt_ff[1] <= hold_cnt_in[1];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_data_ff <= req_data;
      end
      if (s2_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Checks on the pipeline and the carried state.
   `SZQ_ASSERT_IMPL(a_stall_needs_item, req_stall, s1_valid_ff, "stall with empty input stage")
   `SZQ_ASSERT_NEXT(a_advance_fills_result, s2_load, rsp_valid_ff, "advanced beat lost")
   `SZQ_ASSERT_IMPL(a_conf_bound, rsp_valid_ff,
      (rsp_data_ff.left_confidence <= 14'd8192) && (rsp_data_ff.right_confidence <= 14'd8192),
      "confidence above one")
   `SZQ_ASSERT_NEXT(a_hold_steps, s2_load,
      (hold_cnt_ff[0] == '0) || (hold_cnt_ff[0] == $past(hold_cnt_ff[0]) + 1'b1)
      || (hold_cnt_ff[0] == HoldMax), "hold counter jumped")
   `SZQ_ASSERT_NEXT(a_state_holds, !s2_load,
      $stable(hold_cnt_ff[1]) && $stable(zone_hist_ff[0]), "state moved without a beat")

endmodule

`default_nettype wire
